// File: design/cht_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cht_pkg
// Shared widths, codes and storage types of the counting hash table.
// ----------------------------------------------------------------------------
package cht_pkg;

    // Table geometry. The bucket is taken from the low key bits, so the
    // bucket count must be a power of two.
    localparam int BUCKETS = 128;
    localparam int WAYS    = 4;
    localparam int BKT_W   = $clog2(BUCKETS);

    // Field widths.
    localparam int KEY_W     = 31;
    localparam int COUNT_W   = 32;
    localparam int IN_DATA_W = ((KEY_W + 7) / 8) * 8;
    localparam int OUT_DATA_W = ((COUNT_W + 7) / 8) * 8;
    localparam int OUT_USER_W = 2;

    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
    localparam logic [COUNT_W-1:0] COUNT_ONE = COUNT_W'(1);

    // Operation codes carried in the input tuser.
    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_LOOKUP = 1'b1;

    // Bit positions in the output tuser.
    localparam int USR_FOUND = 0;
    localparam int USR_FULL  = 1;

    typedef struct packed {
        logic [KEY_W-1:0]   key;
        logic [COUNT_W-1:0] count;
    } t_way;

    typedef t_way [WAYS-1:0] t_row;

endpackage

// File: design/counting_hash_table_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// counting_hash_table_top
// Keyed occurrence counter with a bucketed, set-associative key store.
// ----------------------------------------------------------------------------
// Each input transaction either counts a key (insert) or asks for its count
// (lookup). The key selects a bucket by its low bits, and each bucket holds a
// fixed number of ways. An insert of a stored key raises its count by one and
// saturates at the all-ones value; an insert of a new key takes the lowest
// free way with count one, and if every way is in use nothing is stored and
// the result flags bucket_full with a zero count. A lookup returns the stored
// count, or zero when the key is absent. Every input transaction yields exactly
// one result transaction, in order. The block takes one transaction per clock
// cycle once the clearing pass is over and while the result side does not
// stall; an accepted item passes through the lookup stage into the result
// register. The rate is set by the bucket memory: one row is read for an item
// in the cycle it is accepted and written back when the item leaves the
// lookup stage, and a row written while the next item reads the same bucket
// is forwarded into that read. The per-way valid bits live in a small memory
// of their own. After reset a clearing pass walks every bucket once and empties
// its valid bits, one bucket per cycle, and o_s_tready stays low until it ends.
// ----------------------------------------------------------------------------
module counting_hash_table_top
    import cht_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // Input stream.
    input  logic                  i_s_tvalid,
    output logic                  o_s_tready,
    input  logic [IN_DATA_W-1:0]  i_s_tdata,   // [30:0] key, [31] zero
    input  logic                  i_s_tuser,   // [0] op (0 insert, 1 lookup)
    // Result stream.
    output logic                  o_m_tvalid,
    input  logic                  i_m_tready,
    output logic [OUT_DATA_W-1:0] o_m_tdata,   // [31:0] count
    output logic [OUT_USER_W-1:0] o_m_tuser    // [0] found, [1] bucket_full
);

    // Bucket rows (keys and counts) live in a memory; the valid bits of each
    // bucket live in a second memory that the clearing pass empties.
    t_row             r_mem   [BUCKETS];
    logic [WAYS-1:0]  r_valid [BUCKETS];

    // Clearing pass after reset.
    logic             r_clearing;
    logic [BKT_W-1:0] r_clr_addr;

    // Lookup stage: the accepted item and the bucket row read for it.
    logic             r_s1_valid;
    logic             r_s1_op;
    logic [KEY_W-1:0] r_s1_key;
    t_row             r_s1_row;
    logic [WAYS-1:0]  r_s1_vld;

    // Result register.
    logic               r_out_valid;
    logic [COUNT_W-1:0] r_out_count;
    logic               r_out_found;
    logic               r_out_full;

    logic               s1_advance;
    logic               s1_fire;
    logic               in_fire;
    logic [BKT_W-1:0]   rd_addr;
    logic [BKT_W-1:0]   wr_addr;
    logic               wr_en;
    logic               bypass;

    logic [WAYS-1:0]    match_vec;
    logic [WAYS-1:0]    hit_vec;
    logic [WAYS-1:0]    free_vec;
    logic [WAYS-1:0]    free_sel;
    logic               hit;
    logic               has_free;
    logic [COUNT_W-1:0] hit_count;
    logic [COUNT_W-1:0] inc_count;

    t_row               n_row;
    logic [WAYS-1:0]    n_vld;
    logic [COUNT_W-1:0] n_count;
    logic               n_found;
    logic               n_full;

    // The lookup stage moves on when the result register is empty or is being
    // drained this cycle; a new item may enter whenever the stage is free or moves
    // on and the clearing pass is over.
    assign s1_advance = !r_out_valid || i_m_tready;
    assign s1_fire    = r_s1_valid && s1_advance;
    assign o_s_tready = !r_clearing && (!r_s1_valid || s1_advance);
    assign in_fire    = i_s_tvalid && o_s_tready;

    assign rd_addr = i_s_tdata[BKT_W-1:0];
    assign wr_addr = r_s1_key[BKT_W-1:0];

    // Way compare. Lowest matching valid way wins, and a new key goes to the
    // lowest invalid way.
    always_comb begin
        for (int w = 0; w < WAYS; w++) begin
            match_vec[w] = r_s1_vld[w] && (r_s1_row[w].key == r_s1_key);
        end
        free_vec = ~r_s1_vld;
        hit_vec  = match_vec & (~match_vec + WAYS'(1));
        free_sel = free_vec & (~free_vec + WAYS'(1));
        hit      = |match_vec;
        has_free = |free_vec;
        hit_count = '0;
        for (int w = 0; w < WAYS; w++) begin
            if (hit_vec[w]) begin
                hit_count = hit_count | r_s1_row[w].count;
            end
        end
        inc_count = (hit_count == COUNT_MAX) ? hit_count : hit_count + COUNT_ONE;
    end

    // Row update and result fields.
    always_comb begin
        n_row   = r_s1_row;
        n_vld   = r_s1_vld;
        n_count = '0;
        n_found = 1'b0;
        n_full  = 1'b0;
        wr_en   = 1'b0;
        if (hit) begin
            n_found = 1'b1;
            if (r_s1_op == OP_INSERT) begin
                n_count = inc_count;
                wr_en   = s1_fire;
                for (int w = 0; w < WAYS; w++) begin
                    if (hit_vec[w]) begin
                        n_row[w].count = inc_count;
                    end
                end
            end else begin
                n_count = hit_count;
            end
        end else if (r_s1_op == OP_INSERT) begin
            if (has_free) begin
                n_count = COUNT_ONE;
                wr_en   = s1_fire;
                for (int w = 0; w < WAYS; w++) begin
                    if (free_sel[w]) begin
                        n_row[w].key   = r_s1_key;
                        n_row[w].count = COUNT_ONE;
                        n_vld[w]       = 1'b1;
                    end
                end
            end else begin
                n_full = 1'b1;
            end
        end
    end

    // A row written back this cycle is forwarded to a read of the same bucket.
    assign bypass = wr_en && (wr_addr == rd_addr);

    // Bucket memory: one write port, one registered read port.
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= n_row;
        end
        if (in_fire) begin
            r_s1_row <= bypass ? n_row : r_mem[rd_addr];
            r_s1_op  <= i_s_tuser;
            r_s1_key <= i_s_tdata[KEY_W-1:0];
        end
    end

    // Valid-bit memory. The clearing pass owns the write port until every
    // bucket has been emptied.
    always_ff @(posedge i_clk) begin
        if (r_clearing) begin
            r_valid[r_clr_addr] <= '0;
        end else if (wr_en) begin
            r_valid[wr_addr] <= n_vld;
        end
    end

    // Clearing pass control and the registered valid-bit read.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing <= 1'b1;
            r_clr_addr <= '0;
            r_s1_vld   <= '0;
        end else begin
            if (r_clearing) begin
                r_clr_addr <= r_clr_addr + BKT_W'(1);
                if (r_clr_addr == BKT_W'(BUCKETS - 1)) begin
                    r_clearing <= 1'b0;
                end
            end
            if (in_fire) begin
                r_s1_vld <= bypass ? n_vld : r_valid[rd_addr];
            end
        end
    end

    // Stage control and result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_fire) begin
                r_s1_valid <= 1'b1;
            end else if (s1_fire) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_fire) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_fire) begin
            r_out_count <= n_count;
            r_out_found <= n_found;
            r_out_full  <= n_full;
        end
    end

    assign o_m_tvalid           = r_out_valid;
    assign o_m_tdata            = OUT_DATA_W'(r_out_count);
    assign o_m_tuser[USR_FOUND] = r_out_found;
    assign o_m_tuser[USR_FULL]  = r_out_full;

endmodule

// File: design/cht_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cht_checker
// Port-level checks on the counting hash table result stream.
// ----------------------------------------------------------------------------
module cht_checker
    import cht_pkg::*;
(
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  o_m_tvalid,
    input logic                  i_m_tready,
    input logic [OUT_DATA_W-1:0] o_m_tdata,
    input logic [OUT_USER_W-1:0] o_m_tuser
);

    // A stalled result holds its contents.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=>
            o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tuser))
        else $error("result changed while stalled");

    // A key cannot be both stored and rejected for a full bucket.
    a_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> !(o_m_tuser[USR_FOUND] && o_m_tuser[USR_FULL]))
        else $error("found and bucket_full both set");

    // A rejected insert reports a zero count.
    a_full_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tuser[USR_FULL] |-> o_m_tdata == '0)
        else $error("bucket_full with nonzero count");

    // A key that was absent ends with a count of zero or one.
    a_new_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !o_m_tuser[USR_FOUND] |-> o_m_tdata <= OUT_DATA_W'(1))
        else $error("absent key with count above one");

    // A stored key always has a nonzero count.
    a_found_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tuser[USR_FOUND] |-> o_m_tdata != '0)
        else $error("stored key with zero count");

endmodule

bind counting_hash_table_top cht_checker u_cht_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tuser  (o_m_tuser)
);

// File: dv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking testbench of the counting hash table.
// ----------------------------------------------------------------------------
// Keys are inserted and looked up through the input stream. A behavioral copy
// of the bucketed store in the bench predicts the count, found and
// bucket_full fields of every result. Each result is compared in order with
// the oldest prediction. The directed tests cover the empty table, the
// extreme keys, a bucket that fills up and back-to-back hits on one bucket.
// The random traffic then works on a few crowded buckets so that hits, misses
// and full buckets are frequent. Both stream sides idle at random, except in
// the back-to-back test and one phase that run at full rate.
// ----------------------------------------------------------------------------
module tb;
    import cht_pkg::*;

    localparam int IDLE_PCT    = 14;    // idle cycles in a hundred, each side
    localparam int STALL_LIMIT = 2000;  // cycles with no transaction at all
    localparam int HOT_BUCKETS = 8;     // buckets that take most random keys
    localparam int TAGS        = 6;     // upper key parts per crowded bucket
    localparam int MAX_REPORTS = 40;

    typedef struct packed {
        logic [COUNT_W-1:0] count;
        logic               found;
        logic               full;
    } t_cht_result;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata = '0;
    logic                  s_tuser = OP_INSERT;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic [OUT_USER_W-1:0] m_tuser;

    // Bench copy of the key store.
    logic [KEY_W-1:0]   tbl_key   [BUCKETS][WAYS];
    logic [COUNT_W-1:0] tbl_count [BUCKETS][WAYS];
    logic               tbl_valid [BUCKETS][WAYS];

    t_cht_result        pending_counts[$];
    logic [KEY_W-1:0]   recent_keys[$];
    logic [KEY_W-BKT_W-1:0] tag_pool [TAGS];
    logic [BKT_W-1:0]   hot_bucket [HOT_BUCKETS];

    bit stalls_on = 1'b1;
    int mismatches = 0;
    int quiet_cycles = 0;

    counting_hash_table_top dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),     // [30:0] key, [31] zero
        .i_s_tuser  (s_tuser),     // [0] op
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata),     // [31:0] count
        .o_m_tuser  (m_tuser)      // [0] found, [1] bucket_full
    );

    initial begin
        forever #1 clk = ~clk;
    end

    // Updates the bench store for one accepted transaction and returns the
    // result it must produce. Saturation would take 2^32 inserts of one key,
    // which no run reaches, but it is modeled all the same.
    function automatic t_cht_result predict_count(logic op, logic [KEY_W-1:0] key);
        t_cht_result r;
        int b;
        int hit;
        int free_way;
        b = int'(key % BUCKETS);
        hit = -1;
        free_way = -1;
        r = '0;
        for (int w = 0; w < WAYS; w++) begin
            if (tbl_valid[b][w]) begin
                if (hit < 0 && tbl_key[b][w] == key) hit = w;
            end else if (free_way < 0) begin
                free_way = w;
            end
        end
        if (hit >= 0) begin
            r.found = 1'b1;
            if (op == OP_INSERT && tbl_count[b][hit] != COUNT_MAX)
                tbl_count[b][hit] = tbl_count[b][hit] + COUNT_ONE;
            r.count = tbl_count[b][hit];
        end else if (op == OP_INSERT) begin
            if (free_way >= 0) begin
                tbl_valid[b][free_way] = 1'b1;
                tbl_key[b][free_way]   = key;
                tbl_count[b][free_way] = COUNT_ONE;
                r.count = COUNT_ONE;
            end else begin
                r.full = 1'b1;
            end
        end
        return r;
    endfunction

    task automatic report_mismatch(string what);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
            $display("[%0t] mismatch: %s", $realtime, what);
    endtask

    // Drives one transaction and returns at the edge where it is accepted.
    // Handshakes are sampled at the falling edge, where every signal already
    // holds the value the next rising edge will see.
    task automatic send_item(logic op, logic [KEY_W-1:0] key);
        int gap;
        gap = 0;
        while (stalls_on && $urandom_range(99) < IDLE_PCT) gap++;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= IN_DATA_W'(key);
        s_tuser  <= op;
        forever begin
            @(negedge clk);
            if (s_tready) break;
        end
        pending_counts.push_back(predict_count(op, key));
        recent_keys.push_back(key);
        if (recent_keys.size() > 16) void'(recent_keys.pop_front());
        @(posedge clk);
    endtask

    // Lowers tvalid and waits until every predicted result has come back.
    task automatic hold_until_drained();
        s_tvalid <= 1'b0;
        do @(posedge clk); while (pending_counts.size() != 0);
    endtask

    // Most keys land in a few crowded buckets, some repeat recent keys and
    // the rest are drawn from the whole key range.
    function automatic logic [KEY_W-1:0] pick_key();
        int unsigned sel;
        sel = $urandom_range(99);
        if (sel < 12)
            return KEY_W'($urandom);
        if (sel < 35 && recent_keys.size() > 0)
            return recent_keys[$urandom_range(recent_keys.size() - 1)];
        return {tag_pool[$urandom_range(TAGS - 1)],
                hot_bucket[$urandom_range(HOT_BUCKETS - 1)]};
    endfunction

    function automatic logic pick_op();
        return ($urandom_range(99) < 65) ? OP_INSERT : OP_LOOKUP;
    endfunction

    // Lookups and inserts on an empty table, with the smallest and largest key.
    task automatic test_empty_table();
        send_item(OP_LOOKUP, '0);
        send_item(OP_LOOKUP, '1);
        send_item(OP_INSERT, '0);
        send_item(OP_INSERT, '1);
        send_item(OP_INSERT, '1);
        send_item(OP_LOOKUP, '0);
        send_item(OP_LOOKUP, '1);
        send_item(OP_LOOKUP, KEY_W'(BUCKETS));      // absent key, same bucket as 0
    endtask

    // Fills one bucket, then inserts a further new key that must be refused.
    task automatic test_full_bucket();
        for (int n = 1; n <= WAYS + 1; n++)
            send_item(OP_INSERT, KEY_W'(n * BUCKETS + 5));
        send_item(OP_INSERT, KEY_W'(2 * BUCKETS + 5));   // stored key still counts
        send_item(OP_LOOKUP, KEY_W'((WAYS + 1) * BUCKETS + 5));
        send_item(OP_LOOKUP, KEY_W'(WAYS * BUCKETS + 5));
        send_item(OP_INSERT, KEY_W'((WAYS + 1) * BUCKETS + 5));
    endtask

    // Consecutive transactions on one bucket exercise the write-back forwarding.
    task automatic test_back_to_back();
        stalls_on = 1'b0;
        repeat (3) send_item(OP_INSERT, KEY_W'(3 * BUCKETS + 9));
        send_item(OP_LOOKUP, KEY_W'(3 * BUCKETS + 9));
        send_item(OP_INSERT, KEY_W'(7 * BUCKETS + 9));
        send_item(OP_LOOKUP, KEY_W'(7 * BUCKETS + 9));
        stalls_on = 1'b1;
    endtask

    task automatic test_random_traffic(int items);
        repeat (items) send_item(pick_op(), pick_key());
    endtask

    // The sender waits for the block to drain completely, then resumes.
    task automatic test_drain_pause();
        hold_until_drained();
        test_random_traffic(50);
        hold_until_drained();
    endtask

    // Full rate on both sides, so every transaction follows its predecessor.
    task automatic test_no_idle(int items);
        stalls_on = 1'b0;
        test_random_traffic(items);
        stalls_on = 1'b1;
    endtask

    // The result side stalls at random while idling is enabled.
    always @(posedge clk) begin
        m_tready <= !stalls_on || ($urandom_range(99) >= IDLE_PCT);
    end

    // Compares each accepted result transaction with the oldest prediction.
    always @(negedge clk) begin : check_results
        t_cht_result want;
        if (rst_n && m_tvalid && m_tready) begin
            if (pending_counts.size() == 0) begin
                report_mismatch($sformatf("result with nothing expected, count %0d",
                                          m_tdata[COUNT_W-1:0]));
            end else begin
                want = pending_counts.pop_front();
                if (m_tdata[COUNT_W-1:0] !== want.count)
                    report_mismatch($sformatf("count %0d, expected %0d",
                                              m_tdata[COUNT_W-1:0], want.count));
                if (m_tuser[USR_FOUND] !== want.found)
                    report_mismatch($sformatf("found %b, expected %b",
                                              m_tuser[USR_FOUND], want.found));
                if (m_tuser[USR_FULL] !== want.full)
                    report_mismatch($sformatf("bucket_full %b, expected %b",
                                              m_tuser[USR_FULL], want.full));
            end
        end
    end

    // Ends a run in which no transaction moves on either side for too long.
    always @(negedge clk) begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("FAILURE");
                $finish;
            end
        end
    end

    initial begin
        for (int b = 0; b < BUCKETS; b++)
            for (int w = 0; w < WAYS; w++)
                tbl_valid[b][w] = 1'b0;
        for (int t = 0; t < TAGS; t++)
            tag_pool[t] = (KEY_W - BKT_W)'($urandom);
        for (int h = 0; h < HOT_BUCKETS; h++)
            hot_bucket[h] = BKT_W'($urandom_range(BUCKETS - 1));

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_table();
        test_full_bucket();
        test_back_to_back();
        test_random_traffic(620);
        test_drain_pause();
        test_no_idle(250);

        // Wait for the last results, then for any extra result that would follow.
        hold_until_drained();
        repeat (8) @(posedge clk);
        if (mismatches == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

// File: sim.f
design/cht_pkg.sv
design/counting_hash_table_top.sv
design/cht_checker.sv
dv/tb.sv
